@@ rtl/core/dtc_pkg.sv @@
package dtc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SEED_BITS_DEF = 32;
    localparam int RI_BITS       = 24;
    localparam int LANES         = 3;
    localparam int SCALE_BITS    = 16;

    localparam logic [31:0] GOLDEN_MULT = 32'd2654435761;
    localparam logic [SCALE_BITS-1:0] SCALE_ONE = 16'd32768;

    // lane 0 gives hue, lane 1 saturation, lane 2 value
    localparam logic [2:0] LANE_BASE [LANES] = '{3'd7, 3'd3, 3'd5};
    localparam logic [31:0] LANE_RECIP [LANES] = '{
        32'((64'd1 << 32) / 7),
        32'((64'd1 << 32) / 3),
        32'((64'd1 << 32) / 5)
    };

    typedef enum logic [1:0] {
        CMD_ISLAND   = 2'd0,
        CMD_INSTANCE = 2'd1,
        CMD_SEMANTIC = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_VALUE_SCALE = 1'b0,
        REG_SAT_SCALE   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic grey;
        logic black;
        logic awake;
    } meta_t;

    typedef struct packed {
        logic [31:0] q;
        logic [2:0]  d;
    } divmod_t;

    // digits of the largest positive seed in the given base
    function automatic int digit_count(input int bits, input int base);
        longint unsigned lim;
        longint unsigned p;
        int n;
        lim = (64'd1 << (bits - 1)) - 64'd1;
        p = 64'd1;
        n = 0;
        while (p <= lim)
        begin
            p = p * longint'(base);
            n = n + 1;
        end
        return n;
    endfunction

    // divide by a small constant through its reciprocal, one correction step
    function automatic divmod_t divmod(input logic [31:0] x, input logic [2:0] base,
                                       input logic [31:0] recip);
        logic [63:0] prod;
        logic [31:0] q;
        logic [31:0] r;
        divmod_t res;
        prod = {32'd0, x} * {32'd0, recip};
        q = prod[63:32];
        r = x - q * {29'd0, base};
        if (r >= {29'd0, base})
        begin
            q = q + 32'd1;
            r = r - {29'd0, base};
        end
        res.q = q;
        res.d = r[2:0];
        return res;
    endfunction

endpackage

@@ rtl/core/id_to_distinct_color.sv @@
// id to distinct color: one request on the slave stream gives one rgb color on the
// master stream. tuser carries the seed mode; tdata carries the island id, object
// hash, body number and awake flag. sleeping bodies get their value and saturation
// scaled by the two configuration registers. the user must write them through
// cfg_we/cfg_index/cfg_wdata only while the pipeline is empty; the block never checks.
// pipeline: 2 seed stages, 2*D radical-inverse stages (D = base-3 digits of the largest
// positive seed, 20 for 32-bit seeds) and 5 color stages.
// each radical-inverse stage does one constant division per lane, one digit split or
// one digit fold, which sets the stage count.
// throughput: one request per cycle unless the output stalls; results in request order.
// reset clears all valid bits and sets both scales to one (32768); no clearing pass.
// when the receiver holds tready low with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated, and while the output register
// is empty the pipeline keeps moving regardless of tready.
module id_to_distinct_color #(
    parameter int FRAC_BITS = dtc_pkg::FRAC_BITS_DEF,
    parameter int SEED_BITS = dtc_pkg::SEED_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // island_id, object_hash, body_number, awake
    input  logic [1:0]   s_axis_tuser,  // cmd

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // red, green, blue

    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata
);

    localparam int RB = dtc_pkg::RI_BITS;

    logic [dtc_pkg::SCALE_BITS-1:0] value_scale_reg;
    logic [dtc_pkg::SCALE_BITS-1:0] sat_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_scale_reg <= dtc_pkg::SCALE_ONE;
            sat_scale_reg   <= dtc_pkg::SCALE_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dtc_pkg::REG_VALUE_SCALE: value_scale_reg <= cfg_wdata;
                dtc_pkg::REG_SAT_SCALE:   sat_scale_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic                 seed_valid;
    logic [SEED_BITS-2:0] seed;
    dtc_pkg::meta_t       seed_meta;

    dtc_seed #(
        .SEED_BITS (SEED_BITS)
    ) u_seed (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .cmd         (s_axis_tuser),
        .island_id   (s_axis_tdata[31:0]),
        .object_hash (s_axis_tdata[63:32]),
        .body_number (s_axis_tdata[95:64]),
        .awake       (s_axis_tdata[96]),
        .out_valid   (seed_valid),
        .seed        (seed),
        .out_meta    (seed_meta)
    );

    logic           ri_valid;
    dtc_pkg::meta_t ri_meta;
    logic [RB-1:0]  ri7, ri3, ri5;

    dtc_radinv #(
        .SEED_BITS (SEED_BITS)
    ) u_radinv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (seed_valid),
        .seed      (seed),
        .in_meta   (seed_meta),
        .out_valid (ri_valid),
        .out_meta  (ri_meta),
        .ri7       (ri7),
        .ri3       (ri3),
        .ri5       (ri5)
    );

    logic [15:0] red, green, blue;

    dtc_hsv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hsv (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (ri_valid),
        .in_meta     (ri_meta),
        .ri7         (ri7),
        .ri3         (ri3),
        .ri5         (ri5),
        .value_scale (value_scale_reg),
        .sat_scale   (sat_scale_reg),
        .out_valid   (m_axis_tvalid),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule

@@ rtl/core/dtc_seed.sv @@
module dtc_seed #(
    parameter int SEED_BITS = dtc_pkg::SEED_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [1:0]             cmd,
    input  logic signed [31:0]     island_id,
    input  logic [31:0]            object_hash,
    input  logic signed [31:0]     body_number,
    input  logic                   awake,
    output logic                   out_valid,
    output logic [SEED_BITS-2:0]   seed,
    output dtc_pkg::meta_t         out_meta
);

    logic        a_valid_reg;
    logic [1:0]  a_cmd_reg;
    logic [31:0] a_island_reg;
    logic [31:0] a_hash_reg;
    logic [31:0] a_body_reg;
    logic        a_awake_reg;
    logic [31:0] a_prod_reg;

    logic                 b_valid_reg;
    logic [SEED_BITS-2:0] b_seed_reg;
    dtc_pkg::meta_t       b_meta_reg;

    logic [31:0]          raw;
    logic [SEED_BITS-1:0] seed_w;
    logic                 seed_pos;
    logic [SEED_BITS-2:0] b_seed_next;
    dtc_pkg::meta_t       b_meta_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cmd_reg    <= cmd;
            a_island_reg <= island_id;
            a_hash_reg   <= object_hash;
            a_body_reg   <= body_number;
            a_awake_reg  <= awake;
            a_prod_reg   <= object_hash * dtc_pkg::GOLDEN_MULT;
            b_seed_reg   <= b_seed_next;
            b_meta_reg   <= b_meta_next;
        end
    end

    always_comb
    begin
        case (a_cmd_reg)
            dtc_pkg::CMD_ISLAND:   raw = a_island_reg + 32'd1;
            dtc_pkg::CMD_INSTANCE: raw = (a_prod_reg ^ a_body_reg) + 32'd1;
            dtc_pkg::CMD_SEMANTIC: raw = a_hash_reg + 32'd1;
            default:               raw = 32'd0;
        endcase
    end

    assign seed_w   = raw[SEED_BITS-1:0];
    assign seed_pos = (|seed_w) && !seed_w[SEED_BITS-1];

    always_comb
    begin
        b_seed_next       = seed_pos ? seed_w[SEED_BITS-2:0] : '0;
        b_meta_next.grey  = (a_cmd_reg == dtc_pkg::CMD_ISLAND) && a_island_reg[31];
        b_meta_next.black = (a_cmd_reg != dtc_pkg::CMD_ISLAND)
                         && (a_cmd_reg != dtc_pkg::CMD_INSTANCE)
                         && (a_cmd_reg != dtc_pkg::CMD_SEMANTIC);
        b_meta_next.awake = a_awake_reg;
    end

    assign out_valid = b_valid_reg;
    assign seed      = b_seed_reg;
    assign out_meta  = b_meta_reg;

endmodule

@@ rtl/core/dtc_radinv.sv @@
module dtc_radinv #(
    parameter int SEED_BITS = dtc_pkg::SEED_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [SEED_BITS-2:0]       seed,
    input  dtc_pkg::meta_t             in_meta,
    output logic                       out_valid,
    output dtc_pkg::meta_t             out_meta,
    output logic [dtc_pkg::RI_BITS-1:0] ri7,
    output logic [dtc_pkg::RI_BITS-1:0] ri3,
    output logic [dtc_pkg::RI_BITS-1:0] ri5
);

    localparam int ND = dtc_pkg::digit_count(SEED_BITS, 3);
    localparam int NS = 2 * ND;
    localparam int RB = dtc_pkg::RI_BITS;

    wire [31:0]          stg_val   [NS+1][dtc_pkg::LANES];
    wire [ND-1:0][2:0]   stg_dig   [NS+1][dtc_pkg::LANES];
    wire                 stg_valid [NS+1];
    wire dtc_pkg::meta_t stg_meta  [NS+1];

    assign stg_valid[0] = in_valid;
    assign stg_meta[0]  = in_meta;

    genvar i, l;
    generate
        for (l = 0; l < dtc_pkg::LANES; l++)
        begin : g_in
            assign stg_val[0][l] = 32'(seed);
            assign stg_dig[0][l] = '0;
        end

        for (i = 0; i < NS; i++)
        begin : g_stage
            logic           valid_reg;
            dtc_pkg::meta_t meta_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg <= 1'b0;
                else if (en)
                    valid_reg <= stg_valid[i];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    meta_reg <= stg_meta[i];
            end

            assign stg_valid[i+1] = valid_reg;
            assign stg_meta[i+1]  = meta_reg;

            for (l = 0; l < dtc_pkg::LANES; l++)
            begin : g_lane
                logic [31:0]        val_reg;
                logic [ND-1:0][2:0] dig_reg;
                logic [31:0]        val_next;
                logic [ND-1:0][2:0] dig_next;
                dtc_pkg::divmod_t   dm;

                if (i < ND)
                begin : g_split
                    // peel one digit off the seed, least significant first
                    always_comb
                    begin
                        dm          = dtc_pkg::divmod(stg_val[i][l], dtc_pkg::LANE_BASE[l],
                                                      dtc_pkg::LANE_RECIP[l]);
                        val_next    = dm.q;
                        dig_next    = stg_dig[i][l];
                        dig_next[i] = dm.d;
                    end
                end
                else
                begin : g_fold
                    logic [RB-1:0] acc;
                    // floor((d * 2^24 + acc) / base), most significant digit first
                    assign acc = (i == ND) ? '0 : stg_val[i][l][RB-1:0];
                    always_comb
                    begin
                        dm       = dtc_pkg::divmod({5'd0, stg_dig[i][l][NS-1-i], acc},
                                                   dtc_pkg::LANE_BASE[l],
                                                   dtc_pkg::LANE_RECIP[l]);
                        val_next = dm.q;
                        dig_next = stg_dig[i][l];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        val_reg <= val_next;
                        dig_reg <= dig_next;
                    end
                end

                assign stg_val[i+1][l] = val_reg;
                assign stg_dig[i+1][l] = dig_reg;
            end
        end
    endgenerate

    assign out_valid = stg_valid[NS];
    assign out_meta  = stg_meta[NS];
    assign ri7       = stg_val[NS][0][RB-1:0];
    assign ri3       = stg_val[NS][1][RB-1:0];
    assign ri5       = stg_val[NS][2][RB-1:0];

endmodule

@@ rtl/core/dtc_hsv.sv @@
module dtc_hsv #(
    parameter int FRAC_BITS = dtc_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  dtc_pkg::meta_t                 in_meta,
    input  logic [dtc_pkg::RI_BITS-1:0]    ri7,
    input  logic [dtc_pkg::RI_BITS-1:0]    ri3,
    input  logic [dtc_pkg::RI_BITS-1:0]    ri5,
    input  logic [dtc_pkg::SCALE_BITS-1:0] value_scale,
    input  logic [dtc_pkg::SCALE_BITS-1:0] sat_scale,
    output logic                           out_valid,
    output logic [15:0]                    red,
    output logic [15:0]                    green,
    output logic [15:0]                    blue
);

    localparam int F  = FRAC_BITS;
    localparam int QW = F + 1;
    localparam int RB = dtc_pkg::RI_BITS;
    localparam int SB = dtc_pkg::SCALE_BITS;

    localparam logic [QW-1:0] ONE_Q  = {1'b1, {F{1'b0}}};
    localparam logic [QW-1:0] HALF_Q = ONE_Q >> 1;
    localparam logic [QW-1:0] C06_Q  = QW'((6 * (64'd1 << F) + 5) / 10);
    localparam logic [QW-1:0] C04_Q  = QW'((4 * (64'd1 << F) + 5) / 10);
    localparam logic [QW-1:0] C07_Q  = QW'((7 * (64'd1 << F) + 5) / 10);
    localparam logic [RB:0]   RI_ONE = {1'b1, {RB{1'b0}}};

    function automatic logic [QW-1:0] scale_clamp(input logic [QW-1:0] x,
                                                  input logic [SB-1:0] k);
        logic [QW+SB-1:0] p;
        logic [QW:0]      r;
        p = {{SB{1'b0}}, x} * {{QW{1'b0}}, k};
        r = p[QW+SB-1:SB-1];
        return (r > {1'b0, ONE_Q}) ? ONE_Q : r[QW-1:0];
    endfunction

    function automatic logic [15:0] to_chan(input logic [QW-1:0] x);
        logic [QW+15:0] w;
        w = {x, 16'd0} >> F;
        return (w > (QW+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    // stage 1: base saturation and value, hue sector and ramp
    logic           h1_valid_reg;
    dtc_pkg::meta_t h1_meta_reg;
    logic [QW-1:0]  h1_s_reg, h1_v_reg;
    logic [2:0]     h1_sector_reg;
    logic [RB:0]    h1_ramp_reg;

    logic [F-1:0]    t3, t5;
    logic [QW+F-1:0] p5;
    logic [QW-1:0]   h1_s_next, h1_v_next;
    logic [RB+2:0]   hp;
    logic [RB:0]     h1_ramp_next;

    assign t3 = ri3[RB-1:RB-F];
    assign t5 = ri5[RB-1:RB-F];
    assign p5 = {{F{1'b0}}, C04_Q} * {{QW{1'b0}}, t5};
    assign hp = {3'd0, ri7} * (RB+3)'(6);

    always_comb
    begin
        h1_s_next = HALF_Q + {2'd0, t3[F-1:1]};
        h1_v_next = in_meta.grey ? C07_Q : C06_Q + p5[QW+F-1:F];
        h1_ramp_next = hp[RB] ? {1'b0, hp[RB-1:0]} : RI_ONE - {1'b0, hp[RB-1:0]};
    end

    // stage 2: sleep scaling
    logic           h2_valid_reg;
    dtc_pkg::meta_t h2_meta_reg;
    logic [QW-1:0]  h2_s_reg, h2_v_reg;
    logic [2:0]     h2_sector_reg;
    logic [RB:0]    h2_ramp_reg;

    // stage 3: chroma
    logic           h3_valid_reg;
    dtc_pkg::meta_t h3_meta_reg;
    logic [QW-1:0]  h3_c_reg, h3_v_reg;
    logic [2:0]     h3_sector_reg;
    logic [RB:0]    h3_ramp_reg;
    logic [2*QW-1:0] pc;

    assign pc = {{QW{1'b0}}, h2_v_reg} * {{QW{1'b0}}, h2_s_reg};

    // stage 4: ramp and offset
    logic           h4_valid_reg;
    dtc_pkg::meta_t h4_meta_reg;
    logic [QW-1:0]  h4_c_reg, h4_x_reg, h4_m_reg, h4_v_reg;
    logic [2:0]     h4_sector_reg;
    logic [QW+RB:0] px;

    assign px = {{(RB+1){1'b0}}, h3_c_reg} * {{QW{1'b0}}, h3_ramp_reg};

    // stage 5: output register
    logic        out_valid_reg;
    logic [15:0] red_reg, green_reg, blue_reg;
    logic [15:0] red_next, green_next, blue_next;
    logic [QW-1:0] r, g, b;

    always_comb
    begin
        r = '0;
        g = '0;
        b = '0;
        case (h4_sector_reg)
            3'd0:
            begin
                r = h4_c_reg;
                g = h4_x_reg;
            end
            3'd1:
            begin
                r = h4_x_reg;
                g = h4_c_reg;
            end
            3'd2:
            begin
                g = h4_c_reg;
                b = h4_x_reg;
            end
            3'd3:
            begin
                g = h4_x_reg;
                b = h4_c_reg;
            end
            3'd4:
            begin
                r = h4_x_reg;
                b = h4_c_reg;
            end
            default:
            begin
                r = h4_c_reg;
                b = h4_x_reg;
            end
        endcase

        if (h4_meta_reg.black)
        begin
            red_next   = 16'd0;
            green_next = 16'd0;
            blue_next  = 16'd0;
        end
        else if (h4_meta_reg.grey)
        begin
            red_next   = to_chan(h4_v_reg);
            green_next = to_chan(h4_v_reg);
            blue_next  = to_chan(h4_v_reg);
        end
        else
        begin
            red_next   = to_chan(r + h4_m_reg);
            green_next = to_chan(g + h4_m_reg);
            blue_next  = to_chan(b + h4_m_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_valid_reg  <= 1'b0;
            h2_valid_reg  <= 1'b0;
            h3_valid_reg  <= 1'b0;
            h4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            h1_valid_reg  <= in_valid;
            h2_valid_reg  <= h1_valid_reg;
            h3_valid_reg  <= h2_valid_reg;
            h4_valid_reg  <= h3_valid_reg;
            out_valid_reg <= h4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_meta_reg   <= in_meta;
            h1_s_reg      <= h1_s_next;
            h1_v_reg      <= h1_v_next;
            h1_sector_reg <= hp[RB+2:RB];
            h1_ramp_reg   <= h1_ramp_next;

            h2_meta_reg   <= h1_meta_reg;
            h2_s_reg      <= h1_meta_reg.awake ? h1_s_reg : scale_clamp(h1_s_reg, sat_scale);
            h2_v_reg      <= h1_meta_reg.awake ? h1_v_reg : scale_clamp(h1_v_reg, value_scale);
            h2_sector_reg <= h1_sector_reg;
            h2_ramp_reg   <= h1_ramp_reg;

            h3_meta_reg   <= h2_meta_reg;
            h3_c_reg      <= pc[F+QW-1:F];
            h3_v_reg      <= h2_v_reg;
            h3_sector_reg <= h2_sector_reg;
            h3_ramp_reg   <= h2_ramp_reg;

            h4_meta_reg   <= h3_meta_reg;
            h4_c_reg      <= h3_c_reg;
            h4_x_reg      <= px[QW+RB-1:RB];
            h4_m_reg      <= h3_v_reg - h3_c_reg;
            h4_v_reg      <= h3_v_reg;
            h4_sector_reg <= h3_sector_reg;

            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

@@ tb/sv/id_to_distinct_color_checker.sv @@
module id_to_distinct_color_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // island_id, object_hash, body_number, awake
    input  logic [1:0]   s_axis_tuser,  // cmd
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [47:0]  m_axis_tdata,  // red, green, blue
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_wdata,
    output int           fail_count,
    output int           colors_pending,
    output int           colors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import dtc_pkg::*;

    localparam longint unsigned ONE_Q  = 64'd65536;
    localparam longint unsigned HALF_Q = 64'd32768;
    localparam longint unsigned C06_Q  = 64'd39322;
    localparam longint unsigned C04_Q  = 64'd26214;
    localparam longint unsigned C07_Q  = 64'd45875;
    localparam longint unsigned RI_ONE = 64'd1 << 24;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgb_t;

    rgb_t expected_colors[$];
    logic [15:0] value_scale_q;
    logic [15:0] sat_scale_q;

    function automatic longint unsigned rad_inv(input longint unsigned seed,
                                                input longint unsigned base);
        longint unsigned num;
        longint unsigned den;
        num = 0;
        den = 1;
        while (seed > 0)
        begin
            num = num * base + seed % base;
            den = den * base;
            seed = seed / base;
        end
        return (num << 24) / den;
    endfunction

    function automatic longint unsigned scaled(input longint unsigned x,
                                               input logic [15:0] scale);
        longint unsigned r;
        r = (x * scale) >> 15;
        return (r > ONE_Q) ? ONE_Q : r;
    endfunction

    function automatic logic [15:0] chan(input longint unsigned x);
        return (x > 64'd65535) ? 16'hFFFF : x[15:0];
    endfunction

    function automatic rgb_t predict_color(input logic [1:0] cmd, input logic [31:0] island,
                                           input logic [31:0] hash, input logic [31:0] body,
                                           input logic awake);
        logic [31:0] seed;
        longint unsigned h7, h3, h5, s, v, c, hp, sector, f, ramp, x, m, r, g, b;
        rgb_t res;
        res = '0;
        h7 = 0;
        h3 = 0;
        h5 = 0;
        r = 0;
        g = 0;
        b = 0;
        if (cmd == 2'd3)
            return res;
        if (cmd == CMD_ISLAND && island[31])
        begin
            v = C07_Q;
            if (!awake)
                v = scaled(v, value_scale_q);
            res.red = chan(v);
            res.green = chan(v);
            res.blue = chan(v);
            return res;
        end
        if (cmd == CMD_ISLAND)
            seed = island + 32'd1;
        else if (cmd == CMD_INSTANCE)
            seed = ((hash * GOLDEN_MULT) ^ body) + 32'd1;
        else
            seed = hash + 32'd1;
        // non-positive seeds leave all inverses at zero
        if (seed != 0 && !seed[31])
        begin
            h7 = rad_inv(seed, 7);
            h3 = rad_inv(seed, 3);
            h5 = rad_inv(seed, 5);
        end
        s = HALF_Q + ((h3 >> 8) >> 1);
        v = C06_Q + ((C04_Q * (h5 >> 8)) >> 16);
        if (!awake)
        begin
            v = scaled(v, value_scale_q);
            s = scaled(s, sat_scale_q);
        end
        c = (v * s) >> 16;
        hp = h7 * 6;
        sector = hp >> 24;
        f = hp & (RI_ONE - 1);
        ramp = sector[0] ? f : (RI_ONE - f);
        x = (c * ramp) >> 24;
        m = v - c;
        case (sector)
            0: begin r = c; g = x; end
            1: begin r = x; g = c; end
            2: begin g = c; b = x; end
            3: begin g = x; b = c; end
            4: begin r = x; b = c; end
            default: begin r = c; b = x; end
        endcase
        res.red = chan(r + m);
        res.green = chan(g + m);
        res.blue = chan(b + m);
        return res;
    endfunction

    task automatic report(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    initial
    begin
        fail_count = 0;
        colors_seen = 0;
        colors_pending = 0;
        value_scale_q = SCALE_ONE;
        sat_scale_q = SCALE_ONE;
    end

    always @(posedge clk)
    begin
        rgb_t want;
        rgb_t got;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_VALUE_SCALE)
                    value_scale_q = cfg_wdata;
                else
                    sat_scale_q = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_colors.push_back(predict_color(s_axis_tuser, s_axis_tdata[31:0],
                    s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[96]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                colors_seen++;
                if (expected_colors.size() == 0)
                begin
                    fail_count++;
                    $display("unexpected color at %0t", $realtime);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (got.red != want.red)
                        report("red", got.red, want.red);
                    if (got.green != want.green)
                        report("green", got.green, want.green);
                    if (got.blue != want.blue)
                        report("blue", got.blue, want.blue);
                end
            end
            colors_pending = expected_colors.size();
        end
    end

endmodule

@@ tb/sv/id_to_distinct_color_test.sv @@
module id_to_distinct_color_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dtc_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;  // island_id, object_hash, body_number, awake
    logic [1:0]   s_axis_tuser;  // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;  // red, green, blue
    logic         cfg_we;
    logic         cfg_index;
    logic [15:0]  cfg_wdata;

    int fail_count;
    int colors_pending;
    int colors_seen;
    int requests_sent;
    int burst_left;
    int idle_cycles;
    int stall_left;
    int ready_mode;

    id_to_distinct_color u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    id_to_distinct_color_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .colors_pending(colors_pending),
        .colors_seen(colors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: runs of always-ready, random stalls and long holds
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    m_axis_tready <= 1'b0;
                    stall_left <= $urandom_range(1, 16);
                end
            endcase
            // a hold lasts one stall, then the receiver goes back to moving
            if (ready_mode == 2)
                ready_mode <= $urandom_range(0, 1);
            else if ($urandom_range(0, 99) < 3)
                ready_mode <= $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [31:0] island,
                                input logic [31:0] hash, input logic [31:0] body,
                                input logic awake);
        int gap;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {7'd0, awake, body, hash, island};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (colors_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_scales(input logic [15:0] value_scale, input logic [15:0] sat_scale);
        cfg_we <= 1'b1;
        cfg_index <= REG_VALUE_SCALE;
        cfg_wdata <= value_scale;
        @(posedge clk);
        cfg_index <= REG_SAT_SCALE;
        cfg_wdata <= sat_scale;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_requests(input int count);
        logic [1:0] cmd;
        logic [31:0] island;
        logic [31:0] hash;
        logic [31:0] body;
        repeat (count)
        begin
            cmd = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            island = $urandom();
            hash = $urandom();
            body = $urandom();
            case ($urandom_range(0, 3))
                0: island = $urandom_range(0, 1000);
                1: body = $urandom_range(0, 64);
                2: hash = $urandom_range(0, 255);
                default: ;
            endcase
            send_request(cmd, island, hash, body, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic directed_requests();
        send_request(CMD_ISLAND, 32'd0, 32'd0, 32'd0, 1'b1);
        send_request(CMD_ISLAND, 32'd1, 32'd0, 32'd0, 1'b0);
        send_request(CMD_ISLAND, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
        send_request(CMD_ISLAND, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(CMD_ISLAND, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1);
        send_request(CMD_ISLAND, 32'h7FFF_FFFE, 32'd0, 32'd0, 1'b0);
        send_request(CMD_INSTANCE, 32'd0, 32'd0, 32'd0, 1'b1);
        send_request(CMD_INSTANCE, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_request(CMD_INSTANCE, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_INSTANCE, 32'd0, 32'd12345, 32'h8000_0000, 1'b0);
        send_request(CMD_SEMANTIC, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_request(CMD_SEMANTIC, 32'd0, 32'h7FFF_FFFF, 32'd0, 1'b0);
        send_request(CMD_SEMANTIC, 32'd0, 32'h7FFF_FFFE, 32'd0, 1'b1);
        send_request(CMD_SEMANTIC, 32'd0, 32'd5, 32'd0, 1'b0);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(2'd3, 32'd7, 32'd7, 32'd7, 1'b0);
        for (int k = 0; k < 6; k++)
            send_request(CMD_SEMANTIC, 32'd0, 32'(k * 3), 32'd0, 1'(k & 1));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_VALUE_SCALE;
        cfg_wdata = '0;
        requests_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        stall_left = 0;
        ready_mode = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();
        random_requests(300);
        wait_drained();
        set_scales(16'd0, 16'd0);
        directed_requests();
        random_requests(280);
        wait_drained();
        set_scales(16'hFFFF, 16'hFFFF);
        directed_requests();
        random_requests(280);
        wait_drained();
        set_scales(16'd32768, 16'd0);
        random_requests(280);
        wait_drained();
        set_scales(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 32768)));
        random_requests(300);
        wait_drained();

        $display("covered %0d color requests in all seed modes, awake and asleep,",
                 requests_sent);
        $display("under five scale settings; %0d colors checked", colors_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
